[rtl/clns_pkg.sv]
// shared types, constants and control-word helpers for the character lcd nibble sequencer
package clns_pkg;

    // display geometry
    localparam int unsigned ROW_COUNT = 2;
    localparam int unsigned COL_COUNT = 16;

    // field widths
    localparam int unsigned ROW_W  = 2;
    localparam int unsigned COL_W  = 6;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STEP_W = 6;

    // configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [0:0]  REG_BACKLIGHT = 1'b0;

    // microprogram entry points
    localparam logic [STEP_W-1:0] INIT_ADDR = 6'd0;
    localparam logic [STEP_W-1:0] BYTE_ADDR = 6'd43;
    localparam logic [STEP_W-1:0] ERR_ADDR  = 6'd49;

    // display command bytes
    localparam logic [BYTE_W-1:0] CLEAR_CMD     = 8'h01;
    localparam logic [BYTE_W-1:0] SET_DDRAM_CMD = 8'h80;

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_WRITE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        NIB_CONST = 2'd0,
        NIB_HI    = 2'd1,
        NIB_LO    = 2'd2
    } nib_src_t;

    typedef struct packed {
        nib_src_t   nib_src;
        logic [3:0] nib;
        logic       en;
        logic       fin;
        logic       err;
    } ucode_t;

    function automatic ucode_t uc_const(input logic [3:0] nib, input logic en,
                                        input logic fin);
        ucode_t w;
        w.nib_src = NIB_CONST;
        w.nib     = nib;
        w.en      = en;
        w.fin     = fin;
        w.err     = 1'b0;
        return w;
    endfunction

    function automatic ucode_t uc_data(input nib_src_t src, input logic en,
                                       input logic fin);
        ucode_t w;
        w.nib_src = src;
        w.nib     = 4'h0;
        w.en      = en;
        w.fin     = fin;
        w.err     = 1'b0;
        return w;
    endfunction

endpackage

[rtl/clns_ucode_rom.sv]
// microprogram rom: one control word per emitted expander byte
module clns_ucode_rom
(
    input  logic [clns_pkg::STEP_W-1:0] step,
    output clns_pkg::ucode_t            word
);

    always_comb
    begin
        case (step)
            // init: backlight-only byte
            6'd0:  word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            // init: function-set nibbles 3, 3, 3, 2
            6'd1:  word = clns_pkg::uc_const(4'h3, 1'b0, 1'b0);
            6'd2:  word = clns_pkg::uc_const(4'h3, 1'b1, 1'b0);
            6'd3:  word = clns_pkg::uc_const(4'h3, 1'b0, 1'b0);
            6'd4:  word = clns_pkg::uc_const(4'h3, 1'b0, 1'b0);
            6'd5:  word = clns_pkg::uc_const(4'h3, 1'b1, 1'b0);
            6'd6:  word = clns_pkg::uc_const(4'h3, 1'b0, 1'b0);
            6'd7:  word = clns_pkg::uc_const(4'h3, 1'b0, 1'b0);
            6'd8:  word = clns_pkg::uc_const(4'h3, 1'b1, 1'b0);
            6'd9:  word = clns_pkg::uc_const(4'h3, 1'b0, 1'b0);
            6'd10: word = clns_pkg::uc_const(4'h2, 1'b0, 1'b0);
            6'd11: word = clns_pkg::uc_const(4'h2, 1'b1, 1'b0);
            6'd12: word = clns_pkg::uc_const(4'h2, 1'b0, 1'b0);
            // init: command 0x28
            6'd13: word = clns_pkg::uc_const(4'h2, 1'b0, 1'b0);
            6'd14: word = clns_pkg::uc_const(4'h2, 1'b1, 1'b0);
            6'd15: word = clns_pkg::uc_const(4'h2, 1'b0, 1'b0);
            6'd16: word = clns_pkg::uc_const(4'h8, 1'b0, 1'b0);
            6'd17: word = clns_pkg::uc_const(4'h8, 1'b1, 1'b0);
            6'd18: word = clns_pkg::uc_const(4'h8, 1'b0, 1'b0);
            // init: command 0x08
            6'd19: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd20: word = clns_pkg::uc_const(4'h0, 1'b1, 1'b0);
            6'd21: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd22: word = clns_pkg::uc_const(4'h8, 1'b0, 1'b0);
            6'd23: word = clns_pkg::uc_const(4'h8, 1'b1, 1'b0);
            6'd24: word = clns_pkg::uc_const(4'h8, 1'b0, 1'b0);
            // init: command 0x01
            6'd25: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd26: word = clns_pkg::uc_const(4'h0, 1'b1, 1'b0);
            6'd27: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd28: word = clns_pkg::uc_const(4'h1, 1'b0, 1'b0);
            6'd29: word = clns_pkg::uc_const(4'h1, 1'b1, 1'b0);
            6'd30: word = clns_pkg::uc_const(4'h1, 1'b0, 1'b0);
            // init: command 0x06
            6'd31: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd32: word = clns_pkg::uc_const(4'h0, 1'b1, 1'b0);
            6'd33: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd34: word = clns_pkg::uc_const(4'h6, 1'b0, 1'b0);
            6'd35: word = clns_pkg::uc_const(4'h6, 1'b1, 1'b0);
            6'd36: word = clns_pkg::uc_const(4'h6, 1'b0, 1'b0);
            // init: command 0x0c
            6'd37: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd38: word = clns_pkg::uc_const(4'h0, 1'b1, 1'b0);
            6'd39: word = clns_pkg::uc_const(4'h0, 1'b0, 1'b0);
            6'd40: word = clns_pkg::uc_const(4'hC, 1'b0, 1'b0);
            6'd41: word = clns_pkg::uc_const(4'hC, 1'b1, 1'b0);
            6'd42: word = clns_pkg::uc_const(4'hC, 1'b0, 1'b1);
            // shared byte routine: high nibble then low nibble of the data register
            6'd43: word = clns_pkg::uc_data(clns_pkg::NIB_HI, 1'b0, 1'b0);
            6'd44: word = clns_pkg::uc_data(clns_pkg::NIB_HI, 1'b1, 1'b0);
            6'd45: word = clns_pkg::uc_data(clns_pkg::NIB_HI, 1'b0, 1'b0);
            6'd46: word = clns_pkg::uc_data(clns_pkg::NIB_LO, 1'b0, 1'b0);
            6'd47: word = clns_pkg::uc_data(clns_pkg::NIB_LO, 1'b1, 1'b0);
            6'd48: word = clns_pkg::uc_data(clns_pkg::NIB_LO, 1'b0, 1'b1);
            // single error result
            6'd49:
            begin
                word     = clns_pkg::uc_const(4'h0, 1'b0, 1'b1);
                word.err = 1'b1;
            end
            default:
            begin
                word     = clns_pkg::uc_const(4'h0, 1'b0, 1'b1);
                word.err = 1'b1;
            end
        endcase
    end

endmodule

[rtl/clns_apb_regs.sv]
// apb configuration register file holding the backlight enable
module clns_apb_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [clns_pkg::PADDR_W-1:0] paddr,
    input  logic [clns_pkg::PDATA_W-1:0] pwdata,
    output logic [clns_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic                         backlight_on
);

    logic backlight_reg;
    logic backlight_next;
    logic hit;

    assign pready = 1'b1;
    // byte offset bits are ignored, the word index selects the register
    assign hit = (paddr[clns_pkg::PADDR_W-1:2] == clns_pkg::REG_BACKLIGHT);

    always_comb
    begin
        backlight_next = backlight_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            backlight_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_reg <= 1'b1;
        end
        else
        begin
            backlight_reg <= backlight_next;
        end
    end

    assign prdata       = hit ? {{(clns_pkg::PDATA_W-1){1'b0}}, backlight_reg} : '0;
    assign backlight_on = backlight_reg;

endmodule

[rtl/char_lcd_nibble_sequencer.sv]
// top level: request dispatch, microcode step counter, byte datapath and output register
// a request loads the step counter; its first byte then enters the output register
// throughput: one byte per cycle from the microcode step counter unless the output stalls;
//   clear, set cursor and write character emit 6 bytes, init 43, a rejected request 1
// the next request is taken in the cycle the final word of the current one is loaded
// reset: display not ready, backlight on, output empty; no clearing pass
module char_lcd_nibble_sequencer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [clns_pkg::PADDR_W-1:0] paddr,
    input  logic [clns_pkg::PDATA_W-1:0] pwdata,
    output logic [clns_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // row[1:0], col[7:2], char_code[15:8]
    input  logic [1:0]                   s_axis_tuser,  // cmd[1:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // expander_byte[7:0]
    output logic                         m_axis_tlast,
    output logic [1:0]                   m_axis_tuser   // status[1:0]
);

    clns_pkg::ucode_t word;
    logic             backlight_on;

    logic                                busy_reg,   busy_next;
    logic [clns_pkg::STEP_W-1:0]         step_reg,   step_next;
    logic [clns_pkg::BYTE_W-1:0]         data_reg,   data_next;
    logic                                rs_reg,     rs_next;
    clns_pkg::status_t                   err_reg,    err_next;
    logic                                ready_reg,  ready_next;
    logic                                m_valid_reg, m_valid_next;
    logic [clns_pkg::BYTE_W-1:0]         m_data_reg, m_data_next;
    logic                                m_last_reg, m_last_next;
    clns_pkg::status_t                   m_user_reg, m_user_next;

    logic                                advance;
    logic                                fin_load;
    logic                                s_acc;
    clns_pkg::cmd_t                      cmd;
    logic [clns_pkg::ROW_W-1:0]          row;
    logic [clns_pkg::COL_W-1:0]          col;
    logic [clns_pkg::CHAR_W-1:0]         char_code;
    logic                                out_of_range;
    logic [3:0]                          nib;
    logic                                rs_bit;
    logic [clns_pkg::BYTE_W-1:0]         byte_val;

    clns_apb_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .backlight_on (backlight_on)
    );

    clns_ucode_rom u_rom
    (
        .step (step_reg),
        .word (word)
    );

    assign cmd       = clns_pkg::cmd_t'(s_axis_tuser);
    assign row       = s_axis_tdata[1:0];
    assign col       = s_axis_tdata[7:2];
    assign char_code = s_axis_tdata[15:8];

    assign out_of_range = (row >= clns_pkg::ROW_W'(clns_pkg::ROW_COUNT)) ||
                          (col >= clns_pkg::COL_W'(clns_pkg::COL_COUNT));

    assign advance       = busy_reg && (!m_valid_reg || m_axis_tready);
    assign fin_load      = advance && word.fin;
    assign s_axis_tready = !busy_reg || fin_load;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // byte datapath driven by the current control word
    always_comb
    begin
        case (word.nib_src)
            clns_pkg::NIB_CONST: nib = word.nib;
            clns_pkg::NIB_HI:    nib = data_reg[7:4];
            clns_pkg::NIB_LO:    nib = data_reg[3:0];
            default:             nib = word.nib;
        endcase
        rs_bit   = (word.nib_src != clns_pkg::NIB_CONST) && rs_reg;
        byte_val = word.err ? '0 : {nib, backlight_on, word.en, 1'b0, rs_bit};
    end

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        data_next    = data_reg;
        rs_next      = rs_reg;
        err_next     = err_reg;
        ready_next   = ready_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        if (advance)
        begin
            step_next    = step_reg + 1'b1;
            m_valid_next = 1'b1;
            m_data_next  = byte_val;
            m_last_next  = word.fin;
            m_user_next  = word.err ? err_reg : clns_pkg::ST_OK;
            if (word.fin)
            begin
                busy_next = 1'b0;
            end
        end

        // dispatch: conditional jump into the microprogram
        if (s_acc)
        begin
            busy_next = 1'b1;
            rs_next   = (cmd == clns_pkg::CMD_WRITE);
            if (cmd == clns_pkg::CMD_INIT)
            begin
                step_next  = clns_pkg::INIT_ADDR;
                ready_next = 1'b1;
            end
            else if (!ready_reg)
            begin
                step_next = clns_pkg::ERR_ADDR;
                err_next  = clns_pkg::ST_NOT_READY;
            end
            else if ((cmd == clns_pkg::CMD_CURSOR) && out_of_range)
            begin
                step_next = clns_pkg::ERR_ADDR;
                err_next  = clns_pkg::ST_RANGE;
            end
            else
            begin
                step_next = clns_pkg::BYTE_ADDR;
                case (cmd)
                    clns_pkg::CMD_CLEAR:  data_next = clns_pkg::CLEAR_CMD;
                    // rows past the first start at ddram 0x40
                    clns_pkg::CMD_CURSOR: data_next = clns_pkg::SET_DDRAM_CMD |
                                                      {1'b0, (row != '0), col};
                    clns_pkg::CMD_WRITE:  data_next = char_code;
                    default:              data_next = char_code;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            step_reg    <= clns_pkg::INIT_ADDR;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        rs_reg     <= rs_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // error results carry a zero byte and end the transaction run
    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_user_reg != clns_pkg::ST_OK)) |-> (m_data_reg == '0) && m_last_reg)
        else $error("error result with nonzero byte or without last");

    a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= clns_pkg::ERR_ADDR))
        else $error("step counter past end of microprogram while busy");

    a_not_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (cmd != clns_pkg::CMD_INIT) && !ready_reg) |=>
        (step_reg == clns_pkg::ERR_ADDR) && (err_reg == clns_pkg::ST_NOT_READY))
        else $error("request before init not routed to error step");

    a_init_ready : assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (cmd == clns_pkg::CMD_INIT)) |=> ready_reg && (step_reg == clns_pkg::INIT_ADDR))
        else $error("init did not start the init program");

endmodule
